[rtl/single_wire_slave_bit_link_core_defines.svh]
// Assertion macros used by the bit link back end.
`ifndef SINGLE_WIRE_SLAVE_BIT_LINK_CORE_DEFINES_SVH
`define SINGLE_WIRE_SLAVE_BIT_LINK_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SWL_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SWL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/swl_pkg.sv]
// Types and constants shared by the bit link modules.
`timescale 1ns / 1ps

package swl_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned GAP_W     = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned EDGE_W    = 8;
    localparam int unsigned BIT_CNT_W = 4;
    localparam int unsigned LEVEL_W   = 6;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic REG_START_GAP = 1'b0;
    localparam logic REG_BIT_GAP   = 1'b1;

    localparam logic [GAP_W-1:0] START_GAP_RST = 8'd7;
    localparam logic [GAP_W-1:0] BIT_GAP_RST   = 8'd3;

    localparam logic [EDGE_W-1:0] EDGES_ZERO_MIN = 8'd3;
    localparam logic [EDGE_W-1:0] EDGES_ZERO_MAX = 8'd4;
    localparam logic [EDGE_W-1:0] EDGES_ONE_MIN  = 8'd6;
    localparam logic [EDGE_W-1:0] EDGES_ONE_MAX  = 8'd8;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 4'd7;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_START,
        KIND_BIT,
        KIND_COUNT,
        KIND_QUEUE,
        KIND_READ,
        KIND_CLEAR
    } swl_kind_t;

    typedef struct packed {
        swl_kind_t         kind;
        logic [BYTE_W-1:0] send_data;
        logic              commit;
    } swl_item_t;

    typedef struct packed {
        logic               reply_valid;
        logic               reply_bit;
        logic               decoded_bit;
        logic               frame_start;
        logic               frame_error;
        logic               byte_done;
        logic               recv_overrun;
        logic               read_valid;
        logic [LEVEL_W-1:0] recv_level;
        logic [LEVEL_W-1:0] send_level;
    } swl_result_t;

endpackage

[rtl/swl_ram.sv]
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module swl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swl_front.sv]
// Front end: classifies incoming items and holds them in a short queue.
`timescale 1ns / 1ps

module swl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swl_pkg::CMD_W-1:0]     command,
    input  logic [swl_pkg::TICK_W-1:0]    elapsed_ticks,
    input  logic [swl_pkg::BYTE_W-1:0]    send_data,
    input  logic                          commit,
    input  logic [swl_pkg::GAP_W-1:0]     start_gap,
    input  logic [swl_pkg::GAP_W-1:0]     bit_gap,
    output swl_pkg::swl_item_t            q_item,
    output logic                          q_valid,
    input  logic                          q_pop
);

    import swl_pkg::*;

    swl_item_t  item_class;
    logic       push;

    swl_item_t  q_mem_reg [QUEUE_DEPTH];
    logic       q_wr_ptr_reg;
    logic       q_wr_ptr_next;
    logic       q_rd_ptr_reg;
    logic       q_rd_ptr_next;
    logic [1:0] q_cnt_reg;
    logic [1:0] q_cnt_next;

    // The start test comes first, so it wins when start_gap <= bit_gap.
    always_comb
    begin
        item_class.send_data = send_data;
        item_class.commit    = commit;
        case (command)
            CMD_EDGE:
            begin
                if (elapsed_ticks >= TICK_W'(start_gap))
                begin
                    item_class.kind = KIND_START;
                end
                else if (elapsed_ticks >= TICK_W'(bit_gap))
                begin
                    item_class.kind = KIND_BIT;
                end
                else
                begin
                    item_class.kind = KIND_COUNT;
                end
            end
            CMD_QUEUE: item_class.kind = KIND_QUEUE;
            CMD_READ:  item_class.kind = KIND_READ;
            CMD_CLEAR: item_class.kind = KIND_CLEAR;
            default:   item_class.kind = KIND_CLEAR;
        endcase
    end

    assign in_ready = (q_cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (q_cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[q_rd_ptr_reg];

    always_comb
    begin
        q_wr_ptr_next = push  ? ~q_wr_ptr_reg : q_wr_ptr_reg;
        q_rd_ptr_next = q_pop ? ~q_rd_ptr_reg : q_rd_ptr_reg;
        q_cnt_next    = q_cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[q_wr_ptr_reg] <= item_class;
        end
    end

endmodule

[rtl/swl_back.sv]
// Back end: bit decoding, send and receive FIFOs, and the result register.
`timescale 1ns / 1ps
`include "single_wire_slave_bit_link_core_defines.svh"

module swl_back #(
    parameter int unsigned RECV_DEPTH = 32,
    parameter int unsigned SEND_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swl_pkg::swl_item_t          q_item,
    input  logic                        q_valid,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output swl_pkg::swl_result_t        out_res,
    output logic [swl_pkg::BYTE_W-1:0]  read_data
);

    import swl_pkg::*;

    localparam int unsigned RAW = $clog2(RECV_DEPTH);
    localparam int unsigned SAW = $clog2(SEND_DEPTH);
    localparam int unsigned RFW = $clog2(RECV_DEPTH + 1);
    localparam int unsigned SFW = $clog2(SEND_DEPTH + 1);

    function automatic logic [RAW-1:0] r_inc(input logic [RAW-1:0] p);
        r_inc = (p == RAW'(RECV_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SAW-1:0] s_inc(input logic [SAW-1:0] p);
        s_inc = (p == SAW'(SEND_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic                 exec;
    logic [BYTE_W-1:0]    shift_cur;
    logic                 bit_ok;
    logic                 bit_val;
    logic                 load_req;
    logic                 bypass;
    logic [SAW-1:0]       s_rd_a;
    logic [SFW-1:0]       s_fill_a;

    logic                 r_we;
    logic                 r_re;
    logic [BYTE_W-1:0]    r_rdata;
    logic                 s_we;
    logic                 s_re;
    logic [SAW-1:0]       s_raddr;
    logic [BYTE_W-1:0]    s_rdata;

    logic [EDGE_W-1:0]    edge_cnt_reg;
    logic [EDGE_W-1:0]    edge_cnt_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [BYTE_W-1:0]    recv_shift_reg;
    logic [BYTE_W-1:0]    recv_shift_next;
    logic [BYTE_W-1:0]    send_shift_reg;
    logic [BYTE_W-1:0]    send_shift_next;
    logic                 load_pend_reg;
    logic                 load_pend_next;
    logic [RAW-1:0]       r_wr_ptr_reg;
    logic [RAW-1:0]       r_wr_ptr_next;
    logic [RAW-1:0]       r_rd_ptr_reg;
    logic [RAW-1:0]       r_rd_ptr_next;
    logic [RFW-1:0]       r_fill_reg;
    logic [RFW-1:0]       r_fill_next;
    logic [SAW-1:0]       s_wr_ptr_reg;
    logic [SAW-1:0]       s_wr_ptr_next;
    logic [SAW-1:0]       s_rd_ptr_reg;
    logic [SAW-1:0]       s_rd_ptr_next;
    logic [SFW-1:0]       s_fill_reg;
    logic [SFW-1:0]       s_fill_next;
    logic                 out_valid_reg;
    swl_result_t          res_reg;
    swl_result_t          res_next;

    assign exec  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = exec;

    // A send byte read from the RAM lands in the cycle after the read; until it is
    // absorbed into the shift register, the RAM output stands in for it.
    assign shift_cur = load_pend_reg ? s_rdata : send_shift_reg;

    always_comb
    begin
        edge_cnt_next   = edge_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        recv_shift_next = recv_shift_reg;
        send_shift_next = shift_cur;
        load_pend_next  = 1'b0;
        r_wr_ptr_next   = r_wr_ptr_reg;
        r_rd_ptr_next   = r_rd_ptr_reg;
        r_fill_next     = r_fill_reg;
        s_wr_ptr_next   = s_wr_ptr_reg;
        s_rd_a          = s_rd_ptr_reg;
        s_fill_a        = s_fill_reg;
        res_next        = '0;
        r_we            = 1'b0;
        r_re            = 1'b0;
        s_we            = 1'b0;
        s_re            = 1'b0;
        s_raddr         = s_rd_ptr_reg;
        load_req        = 1'b0;
        bypass          = 1'b0;
        bit_ok          = 1'b0;
        bit_val         = 1'b0;

        if (exec)
        begin
            case (q_item.kind)
                KIND_START:
                begin
                    bit_cnt_next         = '0;
                    edge_cnt_next        = EDGE_W'(1);
                    res_next.frame_start = 1'b1;
                end
                KIND_BIT:
                begin
                    if (edge_cnt_reg inside {[EDGES_ZERO_MIN:EDGES_ZERO_MAX]})
                    begin
                        bit_ok = 1'b1;
                    end
                    else if (edge_cnt_reg inside {[EDGES_ONE_MIN:EDGES_ONE_MAX]})
                    begin
                        bit_ok  = 1'b1;
                        bit_val = 1'b1;
                    end
                    edge_cnt_next = '0;
                    if (!bit_ok)
                    begin
                        bit_cnt_next         = '0;
                        res_next.frame_error = 1'b1;
                    end
                    else
                    begin
                        recv_shift_next      = {recv_shift_reg[BYTE_W-2:0], bit_val};
                        send_shift_next      = {shift_cur[BYTE_W-2:0], 1'b0};
                        res_next.reply_valid = 1'b1;
                        res_next.reply_bit   = shift_cur[BYTE_W-1];
                        res_next.decoded_bit = bit_val;
                        if (bit_cnt_reg == LAST_BIT_IDX)
                        begin
                            r_we               = 1'b1;
                            r_wr_ptr_next      = r_inc(r_wr_ptr_reg);
                            res_next.byte_done = 1'b1;
                            load_req           = 1'b1;
                            bit_cnt_next       = '0;
                            if (r_fill_reg == RFW'(RECV_DEPTH))
                            begin
                                r_rd_ptr_next         = r_inc(r_wr_ptr_reg);
                                res_next.recv_overrun = 1'b1;
                            end
                            else
                            begin
                                r_fill_next = r_fill_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                        end
                    end
                end
                KIND_COUNT:
                begin
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                end
                KIND_QUEUE:
                begin
                    s_we          = 1'b1;
                    s_wr_ptr_next = s_inc(s_wr_ptr_reg);
                    if (s_fill_reg == SFW'(SEND_DEPTH))
                    begin
                        s_rd_a = s_inc(s_wr_ptr_reg);
                    end
                    else
                    begin
                        s_fill_a = s_fill_reg + 1'b1;
                    end
                    // An empty FIFO hands the new byte straight to the reload.
                    bypass   = (s_fill_reg == '0);
                    load_req = q_item.commit;
                end
                KIND_READ:
                begin
                    if (r_fill_reg != '0)
                    begin
                        r_re                = 1'b1;
                        r_rd_ptr_next       = r_inc(r_rd_ptr_reg);
                        r_fill_next         = r_fill_reg - 1'b1;
                        res_next.read_valid = 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    r_wr_ptr_next = '0;
                    r_rd_ptr_next = '0;
                    r_fill_next   = '0;
                    s_wr_ptr_next = '0;
                    s_rd_a        = '0;
                    s_fill_a      = '0;
                end
                default:
                begin
                end
            endcase
        end

        s_rd_ptr_next = s_rd_a;
        s_fill_next   = s_fill_a;
        if (load_req)
        begin
            if (s_fill_a == '0)
            begin
                send_shift_next = '0;
            end
            else
            begin
                if (bypass)
                begin
                    send_shift_next = q_item.send_data;
                end
                else
                begin
                    s_re           = 1'b1;
                    s_raddr        = s_rd_a;
                    load_pend_next = 1'b1;
                end
                s_rd_ptr_next = s_inc(s_rd_a);
                s_fill_next   = s_fill_a - 1'b1;
            end
        end

        res_next.recv_level = LEVEL_W'(r_fill_next);
        res_next.send_level = LEVEL_W'(s_fill_next);
    end

    swl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RECV_DEPTH)
    ) u_recv_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_wr_ptr_reg),
        .wdata (recv_shift_next),
        .re    (r_re),
        .raddr (r_rd_ptr_reg),
        .rdata (r_rdata)
    );

    swl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SEND_DEPTH)
    ) u_send_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wr_ptr_reg),
        .wdata (q_item.send_data),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg   <= '0;
            bit_cnt_reg    <= '0;
            recv_shift_reg <= '0;
            send_shift_reg <= '0;
            load_pend_reg  <= 1'b0;
            r_wr_ptr_reg   <= '0;
            r_rd_ptr_reg   <= '0;
            r_fill_reg     <= '0;
            s_wr_ptr_reg   <= '0;
            s_rd_ptr_reg   <= '0;
            s_fill_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            edge_cnt_reg   <= edge_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            recv_shift_reg <= recv_shift_next;
            send_shift_reg <= send_shift_next;
            load_pend_reg  <= load_pend_next;
            r_wr_ptr_reg   <= r_wr_ptr_next;
            r_rd_ptr_reg   <= r_rd_ptr_next;
            r_fill_reg     <= r_fill_next;
            s_wr_ptr_reg   <= s_wr_ptr_next;
            s_rd_ptr_reg   <= s_rd_ptr_next;
            s_fill_reg     <= s_fill_next;
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    // The receive RAM output holds until the next read, which waits for
    // this transfer to leave the result register.
    assign read_data = res_reg.read_valid ? r_rdata : '0;

    `SWL_ASSERT_IMP(a_recv_fill_bound, 1'b1, r_fill_reg <= RFW'(RECV_DEPTH), "recv fill above depth")
    `SWL_ASSERT_IMP(a_bit_cnt_range, 1'b1, bit_cnt_reg <= LAST_BIT_IDX, "bit count past a byte")
    `SWL_ASSERT_NEXT(a_pop_gives_result, q_pop, out_valid_reg, "executed item left no result")
    `SWL_ASSERT_IMP(a_overrun_with_byte, out_valid_reg && res_reg.recv_overrun, res_reg.byte_done, "overrun without a stored byte")

endmodule

[rtl/single_wire_slave_bit_link_core.sv]
// Usage: items enter on the in channel (valid/ready) as an edge event or a
// host command; every item yields exactly one result transfer on the out
// channel (valid/ready). start_gap and bit_gap are written over the APB
// port at byte addresses 0 and 4; the user must write them only while no item
// is in flight, which the block itself does not enforce. An accepted item
// waits in the classify queue until the execute stage, which owns the edge
// and bit counters and both FIFO pointers, takes it and loads the result
// register. Throughput: one item per cycle while results are taken; each
// item's state update is compares and pointer steps, and a send byte read
// from the FIFO RAM is forwarded to the next item in the cycle it arrives.
// Reset: counters, shift registers and FIFO pointers clear at once; the FIFO
// RAMs need no clearing pass, and the gap registers return to 7 and 3.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, and in_ready drops once both entries are taken.
`timescale 1ns / 1ps

module single_wire_slave_bit_link_core #(
    parameter int unsigned RECV_DEPTH = 32,
    parameter int unsigned SEND_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swl_pkg::APB_AW-1:0]     paddr,
    input  logic [swl_pkg::APB_DW-1:0]     pwdata,
    output logic [swl_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [swl_pkg::CMD_W-1:0]      command,
    input  logic [swl_pkg::TICK_W-1:0]     elapsed_ticks,
    input  logic [swl_pkg::BYTE_W-1:0]     send_data,
    input  logic                           commit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           reply_valid,
    output logic                           reply_bit,
    output logic                           decoded_bit,
    output logic                           frame_start,
    output logic                           frame_error,
    output logic                           byte_done,
    output logic                           recv_overrun,
    output logic [swl_pkg::BYTE_W-1:0]     read_data,
    output logic                           read_valid,
    output logic [swl_pkg::LEVEL_W-1:0]    recv_level,
    output logic [swl_pkg::LEVEL_W-1:0]    send_level
);

    import swl_pkg::*;

    logic [GAP_W-1:0] start_gap_reg;
    logic [GAP_W-1:0] bit_gap_reg;
    logic             cfg_wr;
    swl_item_t        q_item;
    logic             q_valid;
    logic             q_pop;
    swl_result_t      out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_gap_reg <= START_GAP_RST;
            bit_gap_reg   <= BIT_GAP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_START_GAP: start_gap_reg <= pwdata[GAP_W-1:0];
                REG_BIT_GAP:   bit_gap_reg   <= pwdata[GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_GAP: prdata = APB_DW'(start_gap_reg);
            REG_BIT_GAP:   prdata = APB_DW'(bit_gap_reg);
            default:       prdata = '0;
        endcase
    end

    swl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .elapsed_ticks (elapsed_ticks),
        .send_data     (send_data),
        .commit        (commit),
        .start_gap     (start_gap_reg),
        .bit_gap       (bit_gap_reg),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop)
    );

    swl_back #(
        .RECV_DEPTH (RECV_DEPTH),
        .SEND_DEPTH (SEND_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .read_data (read_data)
    );

    assign reply_valid  = out_res.reply_valid;
    assign reply_bit    = out_res.reply_bit;
    assign decoded_bit  = out_res.decoded_bit;
    assign frame_start  = out_res.frame_start;
    assign frame_error  = out_res.frame_error;
    assign byte_done    = out_res.byte_done;
    assign recv_overrun = out_res.recv_overrun;
    assign read_valid   = out_res.read_valid;
    assign recv_level   = out_res.recv_level;
    assign send_level   = out_res.send_level;

endmodule

[verif/tb.sv]
// Self-checking testbench for the single-wire slave bit link core.
`timescale 1ns / 1ps

module tb;
    import swl_pkg::*;

    localparam int LINK_FIFO_DEPTH = 32;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DIR_ROWS        = 24;

    typedef struct packed {
        logic       reply_valid;
        logic       reply_bit;
        logic       decoded_bit;
        logic       frame_start;
        logic       frame_error;
        logic       byte_done;
        logic       recv_overrun;
        logic [7:0] read_data;
        logic       read_valid;
        logic [5:0] recv_level;
        logic [5:0] send_level;
    } link_res_t;

    // One directed row; the typed columns hold the few fields that can be nonzero.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] ticks;
        logic [7:0]  data;
        logic        cmt;
        logic        typed;
        logic        fs;
        logic        fe;
        logic [5:0]  rl;
        logic [5:0]  sl;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] elapsed_ticks;
    logic [7:0]  send_data;
    logic        commit;
    logic        out_valid;
    logic        out_ready;
    logic        reply_valid;
    logic        reply_bit;
    logic        decoded_bit;
    logic        frame_start;
    logic        frame_error;
    logic        byte_done;
    logic        recv_overrun;
    logic [7:0]  read_data;
    logic        read_valid;
    logic [5:0]  recv_level;
    logic [5:0]  send_level;

    single_wire_slave_bit_link_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .elapsed_ticks (elapsed_ticks),
        .send_data     (send_data),
        .commit        (commit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply_valid   (reply_valid),
        .reply_bit     (reply_bit),
        .decoded_bit   (decoded_bit),
        .frame_start   (frame_start),
        .frame_error   (frame_error),
        .byte_done     (byte_done),
        .recv_overrun  (recv_overrun),
        .read_data     (read_data),
        .read_valid    (read_valid),
        .recv_level    (recv_level),
        .send_level    (send_level)
    );

    // Shadow copy of the link state.
    int         cfg_start;
    int         cfg_bit;
    logic [7:0] edge_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] rx_shift;
    logic [7:0] tx_shift;
    logic [7:0] rx_mem [LINK_FIFO_DEPTH];
    logic [7:0] tx_mem [LINK_FIFO_DEPTH];
    int         rx_wr, rx_rd, rx_fill;
    int         tx_wr, tx_rd, tx_fill;

    link_res_t  pending_q [$];
    stim_row_t  dir_tab [DIR_ROWS];
    int         fail_count;
    int         items_done;
    int         results_seen;
    int         cycles;
    bit         in_hot;
    bit         no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL single_wire_slave_bit_link_core");
                $finish;
            end
        end
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] tx_pop();
        logic [7:0] b;
        b = 8'd0;
        if (tx_fill != 0)
        begin
            b = tx_mem[tx_rd];
            tx_rd = (tx_rd + 1) % LINK_FIFO_DEPTH;
            tx_fill--;
        end
        return b;
    endfunction

    function automatic link_res_t predict_link(input logic [1:0] c, input logic [15:0] t,
                                               input logic [7:0] d, input logic k);
        link_res_t r;
        logic      ok;
        logic      bv;
        r  = '0;
        ok = 1'b0;
        bv = 1'b0;
        case (c)
            CMD_EDGE:
            begin
                if (int'(t) >= cfg_start)
                begin
                    bit_cnt       = 4'd0;
                    edge_cnt      = 8'd1;
                    r.frame_start = 1'b1;
                end
                else if (int'(t) >= cfg_bit)
                begin
                    if (edge_cnt == 8'd3 || edge_cnt == 8'd4)
                    begin
                        ok = 1'b1;
                        bv = 1'b0;
                    end
                    else if (edge_cnt >= 8'd6 && edge_cnt <= 8'd8)
                    begin
                        ok = 1'b1;
                        bv = 1'b1;
                    end
                    if (!ok)
                    begin
                        edge_cnt      = 8'd0;
                        bit_cnt       = 4'd0;
                        r.frame_error = 1'b1;
                    end
                    else
                    begin
                        rx_shift      = {rx_shift[6:0], bv};
                        bit_cnt       = bit_cnt + 4'd1;
                        r.reply_valid = 1'b1;
                        r.reply_bit   = tx_shift[7];
                        r.decoded_bit = bv;
                        tx_shift      = {tx_shift[6:0], 1'b0};
                        edge_cnt      = 8'd0;
                        if (bit_cnt == 4'd8)
                        begin
                            rx_mem[rx_wr] = rx_shift;
                            rx_wr = (rx_wr + 1) % LINK_FIFO_DEPTH;
                            if (rx_fill >= LINK_FIFO_DEPTH)
                            begin
                                rx_rd          = rx_wr;
                                r.recv_overrun = 1'b1;
                            end
                            else
                                rx_fill++;
                            r.byte_done = 1'b1;
                            tx_shift    = tx_pop();
                            bit_cnt     = 4'd0;
                        end
                    end
                end
                else
                    edge_cnt = edge_cnt + 8'd1;
            end
            CMD_QUEUE:
            begin
                tx_mem[tx_wr] = d;
                tx_wr = (tx_wr + 1) % LINK_FIFO_DEPTH;
                if (tx_fill >= LINK_FIFO_DEPTH)
                    tx_rd = tx_wr;
                else
                    tx_fill++;
                if (k)
                    tx_shift = tx_pop();
            end
            CMD_READ:
            begin
                if (rx_fill != 0)
                begin
                    r.read_data  = rx_mem[rx_rd];
                    r.read_valid = 1'b1;
                    rx_rd = (rx_rd + 1) % LINK_FIFO_DEPTH;
                    rx_fill--;
                end
            end
            default:
            begin
                rx_wr   = 0;
                rx_rd   = 0;
                rx_fill = 0;
                tx_wr   = 0;
                tx_rd   = 0;
                tx_fill = 0;
            end
        endcase
        r.recv_level = rx_fill[5:0];
        r.send_level = tx_fill[5:0];
        return r;
    endfunction

    task automatic report_diff(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
            fail_count++;
        end
    endtask

    // Compare every result transfer with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        link_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
                report_diff("result without pending item", 8'd1, 8'd0);
            else
            begin
                want = pending_q.pop_front();
                report_diff("reply_valid", reply_valid, want.reply_valid);
                report_diff("reply_bit", reply_bit, want.reply_bit);
                report_diff("decoded_bit", decoded_bit, want.decoded_bit);
                report_diff("frame_start", frame_start, want.frame_start);
                report_diff("frame_error", frame_error, want.frame_error);
                report_diff("byte_done", byte_done, want.byte_done);
                report_diff("recv_overrun", recv_overrun, want.recv_overrun);
                report_diff("read_data", read_data, want.read_data);
                report_diff("read_valid", read_valid, want.read_valid);
                report_diff("recv_level", recv_level, want.recv_level);
                report_diff("send_level", send_level, want.send_level);
            end
            results_seen++;
        end
    end

    // Receiver: may hold out_ready low for a random stall before each result transfer.
    initial
    begin : receiver
        int n;
        forever
        begin
            n = idle_draw();
            if (n > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic [1:0] c, input logic [15:0] t, input logic [7:0] d,
                             input logic k, input logic typed, input link_res_t typed_res);
        int        gap;
        link_res_t r;
        gap = idle_draw();
        if (gap > 0)
        begin
            if (in_hot)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                in_hot = 1'b0;
                gap--;
            end
            repeat (gap) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        command       <= c;
        elapsed_ticks <= t;
        send_data     <= d;
        commit        <= k;
        do @(posedge clk); while (!in_ready);
        r = predict_link(c, t, d, k);
        if (typed)
            r = typed_res;
        pending_q.push_back(r);
        in_hot = 1'b1;
        items_done++;
    endtask

    task automatic quiesce();
        if (in_hot)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_hot = 1'b0;
        end
    endtask

    task automatic drain();
        quiesce();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_START_GAP)
            cfg_start = int'(val);
        else
            cfg_bit = int'(val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] tick_start();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(cfg_start, 65535));
        return 16'($urandom_range(cfg_start, cfg_start + 20));
    endfunction

    function automatic logic [15:0] tick_short();
        int lim;
        lim = (cfg_bit < cfg_start) ? cfg_bit : cfg_start;
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [15:0] tick_bit();
        if (cfg_bit < cfg_start)
            return 16'($urandom_range(cfg_bit, cfg_start - 1));
        return tick_start();
    endfunction

    task automatic put_edge(input logic [15:0] t);
        send_item(CMD_EDGE, t, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    task automatic host_op();
        case ($urandom_range(0, 2))
            0, 1: send_item(CMD_QUEUE, 16'($urandom), 8'($urandom),
                            ($urandom_range(0, 3) == 0), 1'b0, '0);
            default: send_item(CMD_READ, 16'($urandom), 8'($urandom), 1'($urandom),
                               1'b0, '0);
        endcase
    endtask

    // A start gap followed by nbits bit cells; the noisy form mixes in host
    // commands and the odd invalid edge count.
    task automatic send_frame(input int nbits, input bit clean);
        int target;
        int cur;
        int i;
        put_edge(tick_start());
        cur = 1;
        for (i = 0; i < nbits; i++)
        begin
            if (!clean && $urandom_range(0, 7) == 0)
                host_op();
            if (!clean && $urandom_range(0, 19) == 0)
                target = $urandom_range(0, 10);
            else if ($urandom_range(0, 1) == 1)
                target = $urandom_range(3, 4);
            else
                target = $urandom_range(6, 8);
            repeat ((target > cur) ? target - cur : 0) put_edge(tick_short());
            put_edge(tick_bit());
            cur = 0;
        end
    endtask

    task automatic run_phase(input logic [7:0] sg, input logic [7:0] bg, input int n);
        int target;
        int pick;
        drain();
        cfg_write(REG_START_GAP, sg);
        cfg_write(REG_BIT_GAP, bg);
        no_idle = ($urandom_range(0, 3) == 0);
        target = items_done + n;
        while (items_done < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame($urandom_range(1, 16), 1'b0);
            else if (pick < 70)
                repeat ($urandom_range(1, 6)) host_op();
            else if (pick < 82)
                repeat ($urandom_range(1, 8)) put_edge(16'($urandom));
            else if (pick < 87)
                send_item(CMD_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
            else if (pick < 90)
                repeat (LINK_FIFO_DEPTH + 2)
                    send_item(CMD_QUEUE, 16'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
            else if (pick < 93)
                drain();
            else
                repeat ($urandom_range(1, 4))
                    send_item(CMD_READ, 16'($urandom), 8'($urandom), 1'($urandom),
                              1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        link_res_t typed_res;
        int        i;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        command       = CMD_EDGE;
        elapsed_ticks = '0;
        send_data     = '0;
        commit        = 1'b0;
        out_ready     = 1'b0;
        fail_count    = 0;
        items_done    = 0;
        results_seen  = 0;
        in_hot        = 1'b0;
        no_idle       = 1'b0;
        cfg_start     = int'(START_GAP_RST);
        cfg_bit       = int'(BIT_GAP_RST);
        edge_cnt      = '0;
        bit_cnt       = '0;
        rx_shift      = '0;
        tx_shift      = '0;
        rx_wr = 0; rx_rd = 0; rx_fill = 0;
        tx_wr = 0; tx_rd = 0; tx_fill = 0;
        for (i = 0; i < LINK_FIFO_DEPTH; i++)
        begin
            rx_mem[i] = '0;
            tx_mem[i] = '0;
        end

        // Reset gaps 7 and 3 apply to the whole table.
        dir_tab = '{
            '{CMD_READ,  16'd0,     8'h5A, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd0,     8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'hFFFF,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd3,     8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 6'd0, 6'd0},
            '{CMD_QUEUE, 16'd0,     8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_QUEUE, 16'h1234,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 6'd1},
            '{CMD_CLEAR, 16'hFFFF,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_QUEUE, 16'd0,     8'h80, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 6'd1},
            '{CMD_EDGE,  16'd7,     8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 6'd0, 6'd1},
            '{CMD_EDGE,  16'd0,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd2,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd6,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd0,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd1,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd2,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd0,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd1,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd2,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd4,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd1,     8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_EDGE,  16'd6,     8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 6'd0, 6'd1},
            '{CMD_QUEUE, 16'd0,     8'h55, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0},
            '{CMD_READ,  16'hFFFF,  8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 6'd1},
            '{CMD_EDGE,  16'hFFFF,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 6'd1}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            typed_res             = '0;
            typed_res.frame_start = dir_tab[i].fs;
            typed_res.frame_error = dir_tab[i].fe;
            typed_res.recv_level  = dir_tab[i].rl;
            typed_res.send_level  = dir_tab[i].sl;
            send_item(dir_tab[i].cmd, dir_tab[i].ticks, dir_tab[i].data, dir_tab[i].cmt,
                      dir_tab[i].typed, typed_res);
        end

        run_phase(8'd7, 8'd3, 60);
        run_phase(8'd20, 8'd5, 50);
        run_phase(8'd255, 8'd1, 25);
        run_phase(8'd1, 8'd1, 20);
        run_phase(8'd3, 8'd7, 20);
        run_phase(8'd255, 8'd255, 20);
        run_phase(8'd2, 8'd1, 20);

        // Run the edge counter past 255 so that it wraps to a count of three.
        drain();
        cfg_write(REG_START_GAP, 8'd255);
        cfg_write(REG_BIT_GAP, 8'd200);
        no_idle = 1'b0;
        put_edge(tick_start());
        repeat (258) put_edge(tick_short());
        put_edge(tick_bit());

        run_phase(8'd9, 8'd4, 40);

        quiesce();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS single_wire_slave_bit_link_core");
        else
            $display("FAIL single_wire_slave_bit_link_core");
        $finish;
    end

endmodule

[single_wire_slave_bit_link_core.f]
+incdir+rtl
rtl/swl_pkg.sv
rtl/swl_ram.sv
rtl/swl_front.sv
rtl/swl_back.sv
rtl/single_wire_slave_bit_link_core.sv
verif/tb.sv
